@@ hw/rtl/mrd_pkg.sv @@
`default_nettype none

package mrd_pkg;

  localparam int MaxFrameBytes = 512;
  localparam int PosW          = $clog2(MaxFrameBytes + 1);

  // frame layout offsets
  localparam int TcpHdrBytes = 6;
  localparam int HdrDataOfs  = 3;
  localparam int EchoOfsRtu  = 4;
  localparam int EchoOfsTcp  = 10;

  // result queue
  localparam int OutDepth = 4;
  localparam int OutPtrW  = $clog2(OutDepth);
  localparam int OutCntW  = $clog2(OutDepth + 1);

  localparam logic [7:0] FcExcBit       = 8'h80;
  localparam logic [7:0] FcReadCoils    = 8'h01;
  localparam logic [7:0] FcReadDiscrete = 8'h02;
  localparam logic [7:0] FcReadHolding  = 8'h03;
  localparam logic [7:0] FcReadInput    = 8'h04;
  localparam logic [7:0] FcWriteCoil    = 8'h05;
  localparam logic [7:0] FcWriteReg     = 8'h06;
  localparam logic [7:0] FcWriteCoils   = 8'h0F;
  localparam logic [7:0] FcWriteRegs    = 8'h10;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic KindElement = 1'b0;
  localparam logic KindSummary = 1'b1;

  typedef logic [PosW-1:0] mrd_pos_t;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StShort   = 3'd1,
    StCrc     = 3'd2,
    StProtoId = 3'd3,
    StLength  = 3'd4,
    StOddCnt  = 3'd5,
    StBadFunc = 3'd6,
    StExcLen  = 3'd7
  } mrd_status_e;

  typedef struct packed {
    logic        item_kind;
    logic [15:0] element_value;
    logic [7:0]  element_index;
    mrd_status_e status;
    logic [7:0]  unit_id;
    logic [7:0]  function_code;
    logic        is_exception;
    logic [7:0]  exception_code;
    logic [15:0] transaction_id;
    logic [15:0] echo_value;
    logic        last_of_run;
  } mrd_result_t;

  typedef struct packed {
    logic        elem_v;
    logic        summ_v;
    mrd_result_t elem;
    mrd_result_t summ;
  } mrd_push_t;

  // CRC-16/MODBUS, one byte
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mrd_in_if.sv @@
`default_nettype none

interface mrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, frame_byte, frame_end, input ready);
  modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mrd_out_if.sv @@
`default_nettype none

interface mrd_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [15:0] element_value;
  logic [7:0]  element_index;
  logic [2:0]  status;
  logic [7:0]  unit_id;
  logic [7:0]  function_code;
  logic        is_exception;
  logic [7:0]  exception_code;
  logic [15:0] transaction_id;
  logic [15:0] echo_value;
  logic        last_of_run;

  modport source (output valid, item_kind, element_value, element_index, status, unit_id,
                  function_code, is_exception, exception_code, transaction_id, echo_value,
                  last_of_run, input ready);
  modport sink   (input valid, item_kind, element_value, element_index, status, unit_id,
                  function_code, is_exception, exception_code, transaction_id, echo_value,
                  last_of_run, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mrd_cfg_if.sv @@
`default_nettype none

interface mrd_cfg_if;
  logic valid;
  logic ready;
  logic transport_mode;

  modport source (output valid, transport_mode, input ready);
  modport sink   (input valid, transport_mode, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mrd_core.sv @@
`default_nettype none

module mrd_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             take_i,
  input  wire logic [7:0]       byte_i,
  input  wire logic             end_i,
  input  wire logic             tcp_i,
  output mrd_pkg::mrd_push_t    push_o
);

  mrd_pkg::mrd_pos_t pos_q, pos_d, pos_c;
  logic [15:0]       crc_q, crc_d, crc_c;
  logic [15:0]       tid_q, tid_d, tid_c;
  logic [15:0]       pid_q, pid_d, pid_c;
  logic [15:0]       mlen_q, mlen_d, mlen_c;
  logic [7:0]        unit_q, unit_d, unit_c;
  logic [7:0]        func_q, func_d, func_c;
  logic [7:0]        count_q, count_d, count_c;
  logic [15:0]       echo_q, echo_d, echo_c;
  logic [7:0]        hold_q, hold_d, hold_c;
  logic [7:0]        ecnt_q, ecnt_d, ecnt_c;

  mrd_pkg::mrd_pos_t off, dstart, echo_at, k;
  logic              elem_v;
  logic [15:0]       elem_val;
  logic              exc;
  mrd_pkg::mrd_status_e st;

  // field capture and payload element
  always_comb begin
    off     = tcp_i ? mrd_pkg::mrd_pos_t'(mrd_pkg::TcpHdrBytes) : '0;
    dstart  = off + mrd_pkg::mrd_pos_t'(mrd_pkg::HdrDataOfs);
    echo_at = tcp_i ? mrd_pkg::mrd_pos_t'(mrd_pkg::EchoOfsTcp)
                    : mrd_pkg::mrd_pos_t'(mrd_pkg::EchoOfsRtu);
    k       = pos_q - dstart;

    crc_c   = mrd_pkg::crc_byte(crc_q, byte_i);
    tid_c   = tid_q;
    pid_c   = pid_q;
    mlen_c  = mlen_q;
    unit_c  = unit_q;
    func_c  = func_q;
    count_c = count_q;
    echo_c  = echo_q;
    hold_c  = hold_q;

    if (tcp_i) begin
      if (pos_q == mrd_pkg::mrd_pos_t'(0)) tid_c[15:8]  = byte_i;
      if (pos_q == mrd_pkg::mrd_pos_t'(1)) tid_c[7:0]   = byte_i;
      if (pos_q == mrd_pkg::mrd_pos_t'(2)) pid_c[15:8]  = byte_i;
      if (pos_q == mrd_pkg::mrd_pos_t'(3)) pid_c[7:0]   = byte_i;
      if (pos_q == mrd_pkg::mrd_pos_t'(4)) mlen_c[15:8] = byte_i;
      if (pos_q == mrd_pkg::mrd_pos_t'(5)) mlen_c[7:0]  = byte_i;
    end
    if (pos_q == off)                                  unit_c       = byte_i;
    if (pos_q == off + mrd_pkg::mrd_pos_t'(1))         func_c       = byte_i;
    if (pos_q == off + mrd_pkg::mrd_pos_t'(2))         count_c      = byte_i;
    if (pos_q == echo_at)                              echo_c[15:8] = byte_i;
    if (pos_q == echo_at + mrd_pkg::mrd_pos_t'(1))     echo_c[7:0]  = byte_i;

    // header bytes all sit below the data area, so registered func/count are current
    elem_v   = 1'b0;
    elem_val = '0;
    if (pos_q < mrd_pkg::mrd_pos_t'(mrd_pkg::MaxFrameBytes) && pos_q >= dstart &&
        func_q inside {[mrd_pkg::FcReadCoils:mrd_pkg::FcReadInput]} &&
        k < mrd_pkg::mrd_pos_t'(count_q)) begin
      if (func_q <= mrd_pkg::FcReadDiscrete) begin
        elem_v   = 1'b1;
        elem_val = {8'h00, byte_i};
      end else if (!k[0]) begin
        hold_c = byte_i;
      end else begin
        elem_v   = 1'b1;
        elem_val = {hold_q, byte_i};
      end
    end
    ecnt_c = elem_v ? ecnt_q + 8'd1 : ecnt_q;
    pos_c  = (pos_q < mrd_pkg::mrd_pos_t'(mrd_pkg::MaxFrameBytes)) ?
             pos_q + mrd_pkg::mrd_pos_t'(1) : pos_q;
  end

  // frame check on the captured values
  always_comb begin
    exc = (func_c & mrd_pkg::FcExcBit) != 8'h00;
    st  = mrd_pkg::StOk;
    if (!tcp_i) begin
      if (pos_c < mrd_pkg::mrd_pos_t'(4)) begin
        st = mrd_pkg::StShort;
      end else if (crc_c != 16'h0000) begin
        st = mrd_pkg::StCrc;
      end else if (exc) begin
        st = (pos_c != mrd_pkg::mrd_pos_t'(5)) ? mrd_pkg::StExcLen : mrd_pkg::StOk;
      end else if (func_c inside {[mrd_pkg::FcReadCoils:mrd_pkg::FcReadInput]}) begin
        if (pos_c < mrd_pkg::mrd_pos_t'(5)) begin
          st = mrd_pkg::StShort;
        end else if ({{(mrd_pkg::PosW+1-8){1'b0}}, count_c} + (mrd_pkg::PosW+1)'(5) !=
                     {1'b0, pos_c}) begin
          st = mrd_pkg::StLength;
        end else if (func_c >= mrd_pkg::FcReadHolding && count_c[0]) begin
          st = mrd_pkg::StOddCnt;
        end
      end else if (func_c inside {mrd_pkg::FcWriteCoil, mrd_pkg::FcWriteReg,
                                  mrd_pkg::FcWriteCoils, mrd_pkg::FcWriteRegs}) begin
        st = (pos_c != mrd_pkg::mrd_pos_t'(8)) ? mrd_pkg::StLength : mrd_pkg::StOk;
      end else begin
        st = mrd_pkg::StBadFunc;
      end
    end else begin
      if (pos_c < mrd_pkg::mrd_pos_t'(8)) begin
        st = mrd_pkg::StShort;
      end else if (pid_c != 16'h0000) begin
        st = mrd_pkg::StProtoId;
      end else if (mlen_c < 16'd2 ||
                   {1'b0, mlen_c} + 17'd6 > 17'(pos_c)) begin
        st = mrd_pkg::StLength;
      end else if (exc) begin
        st = (mlen_c != 16'd3) ? mrd_pkg::StExcLen : mrd_pkg::StOk;
      end else if (func_c inside {[mrd_pkg::FcReadCoils:mrd_pkg::FcReadInput]}) begin
        if (mlen_c < 16'd3 || {8'h00, count_c} + 16'd3 != mlen_c) begin
          st = mrd_pkg::StLength;
        end else if (func_c >= mrd_pkg::FcReadHolding && count_c[0]) begin
          st = mrd_pkg::StOddCnt;
        end
      end else if (func_c inside {mrd_pkg::FcWriteCoil, mrd_pkg::FcWriteReg,
                                  mrd_pkg::FcWriteCoils, mrd_pkg::FcWriteRegs}) begin
        st = (mlen_c != 16'd6) ? mrd_pkg::StLength : mrd_pkg::StOk;
      end else begin
        st = mrd_pkg::StBadFunc;
      end
    end
  end

  // results
  always_comb begin
    push_o = '0;
    push_o.elem_v                   = take_i && elem_v;
    push_o.elem.item_kind           = mrd_pkg::KindElement;
    push_o.elem.element_value       = elem_val;
    push_o.elem.element_index       = ecnt_q;
    push_o.elem.status              = mrd_pkg::StOk;
    push_o.elem.last_of_run         = !end_i;

    push_o.summ_v                   = take_i && end_i;
    push_o.summ.item_kind           = mrd_pkg::KindSummary;
    push_o.summ.status              = st;
    push_o.summ.unit_id             = unit_c;
    push_o.summ.function_code       = func_c;
    push_o.summ.is_exception        = exc;
    push_o.summ.exception_code      = exc ? count_c : 8'h00;
    push_o.summ.transaction_id      = tcp_i ? tid_c : 16'h0000;
    push_o.summ.echo_value          = (func_c == mrd_pkg::FcWriteCoil ||
                                       func_c == mrd_pkg::FcWriteReg) ? echo_c : 16'h0000;
    push_o.summ.last_of_run         = 1'b1;
  end

  // next frame state: hold, advance, or clear at frame end
  always_comb begin
    pos_d   = pos_q;
    crc_d   = crc_q;
    tid_d   = tid_q;
    pid_d   = pid_q;
    mlen_d  = mlen_q;
    unit_d  = unit_q;
    func_d  = func_q;
    count_d = count_q;
    echo_d  = echo_q;
    hold_d  = hold_q;
    ecnt_d  = ecnt_q;
    if (take_i) begin
      if (end_i) begin
        pos_d   = '0;
        crc_d   = mrd_pkg::CrcInit;
        tid_d   = '0;
        pid_d   = '0;
        mlen_d  = '0;
        unit_d  = '0;
        func_d  = '0;
        count_d = '0;
        echo_d  = '0;
        hold_d  = '0;
        ecnt_d  = '0;
      end else begin
        pos_d   = pos_c;
        crc_d   = crc_c;
        tid_d   = tid_c;
        pid_d   = pid_c;
        mlen_d  = mlen_c;
        unit_d  = unit_c;
        func_d  = func_c;
        count_d = count_c;
        echo_d  = echo_c;
        hold_d  = hold_c;
        ecnt_d  = ecnt_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      crc_q   <= mrd_pkg::CrcInit;
      tid_q   <= '0;
      pid_q   <= '0;
      mlen_q  <= '0;
      unit_q  <= '0;
      func_q  <= '0;
      count_q <= '0;
      echo_q  <= '0;
      hold_q  <= '0;
      ecnt_q  <= '0;
    end else begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      tid_q   <= tid_d;
      pid_q   <= pid_d;
      mlen_q  <= mlen_d;
      unit_q  <= unit_d;
      func_q  <= func_d;
      count_q <= count_d;
      echo_q  <= echo_d;
      hold_q  <= hold_d;
      ecnt_q  <= ecnt_d;
    end
  end

`ifndef SYNTHESIS
  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= mrd_pkg::mrd_pos_t'(mrd_pkg::MaxFrameBytes))
    else $error("byte position past saturation limit");
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.summ_v |=> (pos_q == '0 && crc_q == mrd_pkg::CrcInit && ecnt_q == '0))
    else $error("frame state not cleared after frame end");
  a_elem_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.elem_v |-> (func_q >= mrd_pkg::FcReadCoils && func_q <= mrd_pkg::FcReadInput))
    else $error("payload element outside a read response");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/mrd_result_fifo.sv @@
`default_nettype none

module mrd_result_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mrd_pkg::mrd_push_t  push_i,
  input  wire logic                pop_i,
  output logic                     valid_o,
  output mrd_pkg::mrd_result_t     data_o,
  output logic                     room_o
);

  mrd_pkg::mrd_result_t              mem_q [mrd_pkg::OutDepth];
  logic [mrd_pkg::OutPtrW-1:0]       wp_q, wp_d, rp_q, rp_d;
  logic [mrd_pkg::OutCntW-1:0]       count_q, count_d;
  logic [1:0]                        n_push;
  logic                              pop;
  mrd_pkg::mrd_result_t              first;

  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rp_q];
  // an end byte can push two results, so keep two slots free before taking a byte
  assign room_o  = count_q <= mrd_pkg::OutCntW'(mrd_pkg::OutDepth - 2);
  assign pop     = pop_i && valid_o;
  assign n_push  = {1'b0, push_i.elem_v} + {1'b0, push_i.summ_v};
  assign first   = push_i.elem_v ? push_i.elem : push_i.summ;

  always_comb begin
    wp_d    = wp_q + mrd_pkg::OutPtrW'(n_push);
    rp_d    = pop ? rp_q + mrd_pkg::OutPtrW'(1) : rp_q;
    count_d = count_q + mrd_pkg::OutCntW'(n_push) - mrd_pkg::OutCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wp_q] <= first;
    end
    if (n_push == 2'd2) begin
      mem_q[wp_q + mrd_pkg::OutPtrW'(1)] <= push_i.summ;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      count_q <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= mrd_pkg::OutCntW'(mrd_pkg::OutDepth))
    else $error("result queue overflow");
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.elem_v || push_i.summ_v) |-> room_o)
    else $error("push without room for two results");
  a_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !pop_i) |=> count_q >= $past(count_q))
    else $error("result dropped while stalled");
  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == mrd_pkg::OutCntW'(mrd_pkg::OutDepth)) ||
    (wp_q - rp_q == mrd_pkg::OutPtrW'(count_q)))
    else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/modbus_response_deframer.sv @@
// Modbus response deframer, RTU or TCP framing.
// in_i  : one frame byte per beat, frame_end set on the last byte of the frame.
// out_o : result beats. item_kind 0 is a provisional payload element (coil byte
//         for FC01/02, big-endian word for FC03/04); item_kind 1 is the frame
//         summary with status and header fields. last_of_run marks the final
//         result caused by one byte (an end byte can cause an element and a
//         summary).
// cfg_i : transport_mode write, 0 RTU with CRC, 1 TCP with MBAP header; always
//         ready; written only while the block is idle, a user rule not enforced.
// Timing: a byte lands in the input register at its beat, is parsed once the
//         queue has room (CRC, field capture, checks) and its results are written
//         to a 4-entry result queue, from which they are offered; a result thus
//         passes the input register and the queue. One byte per cycle is sustained
//         while the queue has room; the output channel moves one result per cycle,
//         so a frame end with a payload element costs two output beats.
// Stall: when out_o is held, the queue fills; bytes are taken while it has two
//         free slots, then in_i.ready drops. Nothing is lost or repeated.
// Reset: rst_ni clears frame state (CRC to 0xFFFF), empties the queue and sets
//         RTU mode. The block is ready right after reset.
`default_nettype none

module modbus_response_deframer (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mrd_in_if.sink     in_i,
  mrd_out_if.source  out_o,
  mrd_cfg_if.sink    cfg_i
);

  logic                 mode_q, mode_d;
  logic                 in_valid_q, in_valid_d;
  logic [7:0]           in_byte_q;
  logic                 in_end_q;
  logic                 take;
  logic                 room;
  mrd_pkg::mrd_push_t   push;
  mrd_pkg::mrd_result_t res;

  assign cfg_i.ready = 1'b1;
  assign take        = in_valid_q && room;
  assign in_i.ready  = !in_valid_q || take;

  always_comb begin
    mode_d     = (cfg_i.valid && cfg_i.ready) ? cfg_i.transport_mode : mode_q;
    in_valid_d = (in_i.valid && in_i.ready) ? 1'b1 : (take ? 1'b0 : in_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      in_valid_q <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.frame_byte;
      in_end_q  <= in_i.frame_end;
    end
  end

  mrd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .byte_i (in_byte_q),
    .end_i  (in_end_q),
    .tcp_i  (mode_q),
    .push_o (push)
  );

  mrd_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_o.ready),
    .valid_o (out_o.valid),
    .data_o  (res),
    .room_o  (room)
  );

  assign out_o.item_kind      = res.item_kind;
  assign out_o.element_value  = res.element_value;
  assign out_o.element_index  = res.element_index;
  assign out_o.status         = res.status;
  assign out_o.unit_id        = res.unit_id;
  assign out_o.function_code  = res.function_code;
  assign out_o.is_exception   = res.is_exception;
  assign out_o.exception_code = res.exception_code;
  assign out_o.transaction_id = res.transaction_id;
  assign out_o.echo_value     = res.echo_value;
  assign out_o.last_of_run    = res.last_of_run;

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;

  localparam int QuietLimit   = 4000;
  localparam int HoldCycles   = 400;
  localparam int SettleCycles = 8;
  localparam int PhaseBytes   = 55;

  logic clk;
  logic rst_n;

  mrd_in_if  in_bus ();
  mrd_out_if out_bus ();
  mrd_cfg_if cfg_bus ();

  modbus_response_deframer dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus),
    .out_o (out_bus),
    .cfg_i (cfg_bus)
  );

  // predictor state, one frame at a time
  logic                     mode_tcp;
  logic [mrd_pkg::PosW-1:0] frm_pos;
  logic [15:0]              frm_crc;
  logic [15:0]              frm_tid;
  logic [15:0]              frm_pid;
  logic [15:0]              frm_len;
  logic [7:0]               frm_unit;
  logic [7:0]               frm_func;
  logic [7:0]               frm_count;
  logic [15:0]              frm_echo;
  logic [7:0]               frm_hold;
  logic [7:0]               frm_elem;

  mrd_pkg::mrd_result_t pending_results[$];
  bit [7:0]             pdu_buf[$];
  bit [7:0]             frame_buf[$];

  int send_idle_pct;
  int stall_pct;
  bit hold_req;
  int hold_left;

  int mismatches;
  int bytes_taken;
  int in_stalls;
  int elements_checked;
  int summaries_checked;
  int quiet_cycles;
  bit [7:0] status_seen;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- queues

  function automatic void expect_result(mrd_pkg::mrd_result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void add_pdu_byte(bit [7:0] b);
    pdu_buf.insert(pdu_buf.size(), b);
  endfunction

  function automatic void add_frame_byte(bit [7:0] b);
    frame_buf.insert(frame_buf.size(), b);
  endfunction

  // ---------------------------------------------------------------- predictor

  function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ mrd_pkg::CrcPoly;
      end
    end
    return c;
  endfunction

  function automatic bit is_read_fc(logic [7:0] f);
    return f >= mrd_pkg::FcReadCoils && f <= mrd_pkg::FcReadInput;
  endfunction

  function automatic bit is_write_fc(logic [7:0] f);
    return f == mrd_pkg::FcWriteCoil || f == mrd_pkg::FcWriteReg ||
           f == mrd_pkg::FcWriteCoils || f == mrd_pkg::FcWriteRegs;
  endfunction

  function automatic void clear_frame();
    frm_pos   = '0;
    frm_crc   = mrd_pkg::CrcInit;
    frm_tid   = '0;
    frm_pid   = '0;
    frm_len   = '0;
    frm_unit  = '0;
    frm_func  = '0;
    frm_count = '0;
    frm_echo  = '0;
    frm_hold  = '0;
    frm_elem  = '0;
  endfunction

  function automatic mrd_pkg::mrd_status_e frame_check(int len);
    bit exc;
    exc = frm_func[7];
    if (!mode_tcp) begin
      if (len < 4) return mrd_pkg::StShort;
      if (frm_crc != 16'h0000) return mrd_pkg::StCrc;
      if (exc) return (len != 5) ? mrd_pkg::StExcLen : mrd_pkg::StOk;
      if (is_read_fc(frm_func)) begin
        if (len < 5) return mrd_pkg::StShort;
        if (5 + frm_count != len) return mrd_pkg::StLength;
        if (frm_func >= mrd_pkg::FcReadHolding && frm_count[0]) return mrd_pkg::StOddCnt;
        return mrd_pkg::StOk;
      end
      if (is_write_fc(frm_func)) return (len != 8) ? mrd_pkg::StLength : mrd_pkg::StOk;
      return mrd_pkg::StBadFunc;
    end
    if (len < 8) return mrd_pkg::StShort;
    if (frm_pid != 16'h0000) return mrd_pkg::StProtoId;
    if (frm_len < 2 || 6 + frm_len > len) return mrd_pkg::StLength;
    if (exc) return (frm_len != 3) ? mrd_pkg::StExcLen : mrd_pkg::StOk;
    if (is_read_fc(frm_func)) begin
      if (frm_len < 3 || 3 + frm_count != frm_len) return mrd_pkg::StLength;
      if (frm_func >= mrd_pkg::FcReadHolding && frm_count[0]) return mrd_pkg::StOddCnt;
      return mrd_pkg::StOk;
    end
    if (is_write_fc(frm_func)) return (frm_len != 6) ? mrd_pkg::StLength : mrd_pkg::StOk;
    return mrd_pkg::StBadFunc;
  endfunction

  // expected results of one accepted byte go to pending_results
  function automatic void deframe_byte(logic [7:0] b, logic fin);
    mrd_pkg::mrd_result_t r;
    int idx, off, dstart, echo_at, k, made;
    idx     = frm_pos;
    off     = mode_tcp ? mrd_pkg::TcpHdrBytes : 0;
    dstart  = off + mrd_pkg::HdrDataOfs;
    echo_at = mode_tcp ? mrd_pkg::EchoOfsTcp : mrd_pkg::EchoOfsRtu;
    made    = 0;

    frm_crc = crc_next(frm_crc, b);
    if (mode_tcp) begin
      case (idx)
        0: frm_tid[15:8] = b;
        1: frm_tid[7:0]  = b;
        2: frm_pid[15:8] = b;
        3: frm_pid[7:0]  = b;
        4: frm_len[15:8] = b;
        5: frm_len[7:0]  = b;
        default: ;
      endcase
    end
    if (idx == off)         frm_unit  = b;
    if (idx == off + 1)     frm_func  = b;
    if (idx == off + 2)     frm_count = b;
    if (idx == echo_at)     frm_echo[15:8] = b;
    if (idx == echo_at + 1) frm_echo[7:0]  = b;

    if (idx < mrd_pkg::MaxFrameBytes && idx >= dstart && is_read_fc(frm_func)) begin
      k = idx - dstart;
      if (k < frm_count) begin
        r = '0;
        r.item_kind     = mrd_pkg::KindElement;
        r.element_index = frm_elem;
        if (frm_func <= mrd_pkg::FcReadDiscrete) begin
          r.element_value = {8'h00, b};
          made = 1;
        end else if (k % 2 == 0) begin
          frm_hold = b;
        end else begin
          r.element_value = {frm_hold, b};
          made = 1;
        end
        if (made != 0) begin
          frm_elem = frm_elem + 8'd1;
          expect_result(r);
        end
      end
    end

    if (frm_pos < mrd_pkg::MaxFrameBytes) frm_pos = frm_pos + 1'b1;

    if (fin) begin
      r = '0;
      r.item_kind      = mrd_pkg::KindSummary;
      r.status         = frame_check(frm_pos);
      r.unit_id        = frm_unit;
      r.function_code  = frm_func;
      r.is_exception   = frm_func[7];
      r.exception_code = frm_func[7] ? frm_count : 8'h00;
      r.transaction_id = mode_tcp ? frm_tid : 16'h0000;
      r.echo_value     = (frm_func == mrd_pkg::FcWriteCoil ||
                          frm_func == mrd_pkg::FcWriteReg) ? frm_echo : 16'h0000;
      expect_result(r);
      made++;
      clear_frame();
    end

    if (made != 0) begin
      r = pending_results[pending_results.size() - 1];
      r.last_of_run = 1'b1;
      pending_results[pending_results.size() - 1] = r;
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic flag_mismatch(string msg);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                              elements_checked + summaries_checked, name, got, want));
    end
  endtask

  task automatic check_result();
    mrd_pkg::mrd_result_t want;
    if (pending_results.size() == 0) begin
      flag_mismatch($sformatf("result of kind %0d with nothing expected", out_bus.item_kind));
      return;
    end
    want = pending_results.pop_front();
    compare_field("item_kind",      out_bus.item_kind,      want.item_kind);
    compare_field("element_value",  out_bus.element_value,  want.element_value);
    compare_field("element_index",  out_bus.element_index,  want.element_index);
    compare_field("status",         out_bus.status,         want.status);
    compare_field("unit_id",        out_bus.unit_id,        want.unit_id);
    compare_field("function_code",  out_bus.function_code,  want.function_code);
    compare_field("is_exception",   out_bus.is_exception,   want.is_exception);
    compare_field("exception_code", out_bus.exception_code, want.exception_code);
    compare_field("transaction_id", out_bus.transaction_id, want.transaction_id);
    compare_field("echo_value",     out_bus.echo_value,     want.echo_value);
    compare_field("last_of_run",    out_bus.last_of_run,    want.last_of_run);
    if (want.item_kind == mrd_pkg::KindSummary) begin
      summaries_checked++;
      status_seen[want.status] = 1'b1;
    end else begin
      elements_checked++;
    end
  endtask

  // results are checked before the byte of this edge is predicted: a byte
  // can never produce a result on the edge it is taken
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        check_result();
      end
      if (in_bus.valid && in_bus.ready) begin
        bytes_taken++;
        deframe_byte(in_bus.frame_byte, in_bus.frame_end);
      end else if (in_bus.valid) begin
        in_stalls++;
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        mode_tcp = cfg_bus.transport_mode;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("timeout: no beat for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_results.size());
      $display("** modbus_response_deframer: FAILED **");
      $finish;
    end
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_byte(logic [7:0] b, logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.frame_byte <= b;
    in_bus.frame_end  <= fin;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  task automatic send_slice(int first, int stop);
    for (int i = first; i < stop; i++) begin
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
    end
  endtask

  task automatic wait_drain();
    in_bus.valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    // bytes without results may still be in flight
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_transport(logic tcp);
    wait_drain();
    cfg_bus.valid          <= 1'b1;
    cfg_bus.transport_mode <= tcp;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // frame_buf = pdu_buf wrapped in MBAP header or followed by CRC
  function automatic void wrap_pdu(bit tcp, bit [15:0] tid);
    logic [15:0] c;
    frame_buf.delete();
    if (tcp) begin
      add_frame_byte(tid[15:8]);
      add_frame_byte(tid[7:0]);
      add_frame_byte(8'h00);
      add_frame_byte(8'h00);
      add_frame_byte(8'(pdu_buf.size() >> 8));
      add_frame_byte(8'(pdu_buf.size()));
    end
    foreach (pdu_buf[i]) add_frame_byte(pdu_buf[i]);
    if (!tcp) begin
      c = mrd_pkg::CrcInit;
      foreach (pdu_buf[i]) c = crc_next(c, pdu_buf[i]);
      add_frame_byte(c[7:0]);
      add_frame_byte(c[15:8]);
    end
  endfunction

  task automatic make_random_frame(bit tcp);
    int sel, cnt, pos;
    bit [7:0] fc;
    frame_buf.delete();
    pdu_buf.delete();
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 14)) add_frame_byte(8'($urandom));
      return;
    end
    add_pdu_byte(8'($urandom));
    sel = $urandom_range(99);
    if (sel < 50) begin
      fc  = 8'($urandom_range(mrd_pkg::FcReadCoils, mrd_pkg::FcReadInput));
      cnt = ($urandom_range(24) == 0) ? $urandom_range(255) : $urandom_range(16);
      if (fc >= mrd_pkg::FcReadHolding && $urandom_range(7) != 0) cnt = cnt & 'hFE;
      add_pdu_byte(fc);
      add_pdu_byte(8'(cnt));
      repeat (cnt) add_pdu_byte(8'($urandom));
    end else if (sel < 72) begin
      case ($urandom_range(3))
        0: fc = mrd_pkg::FcWriteCoil;
        1: fc = mrd_pkg::FcWriteReg;
        2: fc = mrd_pkg::FcWriteCoils;
        default: fc = mrd_pkg::FcWriteRegs;
      endcase
      add_pdu_byte(fc);
      repeat (4) add_pdu_byte(8'($urandom));
    end else if (sel < 88) begin
      add_pdu_byte(mrd_pkg::FcExcBit | 8'($urandom_range(127)));
      add_pdu_byte(8'($urandom));
    end else begin
      add_pdu_byte(8'($urandom));
      repeat ($urandom_range(6)) add_pdu_byte(8'($urandom));
    end
    wrap_pdu(tcp, 16'($urandom));

    // broken frames
    if ($urandom_range(99) < 22) begin
      pos = $urandom_range(frame_buf.size() - 1);
      case ($urandom_range(4))
        0: frame_buf[pos] = frame_buf[pos] ^ 8'($urandom_range(1, 255));
        1: if (frame_buf.size() > 1) void'(frame_buf.pop_back());
        2: add_frame_byte(8'($urandom));
        3: begin
          pos = (tcp ? mrd_pkg::TcpHdrBytes : 0) + 2;
          if (pos < frame_buf.size()) frame_buf[pos] = 8'($urandom);
        end
        default: begin
          if (tcp) begin
            frame_buf[2 + $urandom_range(1)] = 8'($urandom_range(1, 255));
          end else begin
            while (frame_buf.size() > 3) void'(frame_buf.pop_back());
          end
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_rtu_basic();
    write_transport(1'b0);
    pdu_buf = '{8'h00, mrd_pkg::FcReadCoils, 8'h01, 8'hFF};
    wrap_pdu(1'b0, 16'h0000);
    send_slice(0, frame_buf.size());
    pdu_buf = '{8'hFF, mrd_pkg::FcExcBit | mrd_pkg::FcReadHolding, 8'h02};
    wrap_pdu(1'b0, 16'h0000);
    send_slice(0, frame_buf.size());
    // a lone byte is a short frame
    frame_buf = '{8'h00};
    send_slice(0, 1);
    pdu_buf = '{8'h11, mrd_pkg::FcWriteReg, 8'h00, 8'h01, 8'hAB, 8'hCD};
    wrap_pdu(1'b0, 16'h0000);
    send_slice(0, frame_buf.size());
  endtask

  task automatic test_tcp_basic();
    write_transport(1'b1);
    pdu_buf = '{8'h01, mrd_pkg::FcReadInput, 8'h02, 8'h80, 8'h7F};
    wrap_pdu(1'b1, 16'hBEEF);
    send_slice(0, frame_buf.size());
    pdu_buf = '{8'h07, mrd_pkg::FcWriteCoil, 8'h00, 8'h13, 8'hFF, 8'h00};
    wrap_pdu(1'b1, 16'hFFFF);
    send_slice(0, frame_buf.size());
  endtask

  // frame state survives a transport change between bytes
  task automatic test_mode_switch_midframe();
    pdu_buf = '{8'h21, mrd_pkg::FcReadHolding, 8'h04, 8'hDE, 8'hAD, 8'hBE, 8'hEF};
    wrap_pdu(1'b1, 16'h1234);
    send_slice(0, 5);
    write_transport(1'b0);
    send_slice(5, frame_buf.size());
    pdu_buf = '{8'h05, mrd_pkg::FcReadCoils, 8'h02, 8'h0F, 8'hF0};
    wrap_pdu(1'b0, 16'h0000);
    send_slice(0, 2);
    write_transport(1'b1);
    send_slice(2, frame_buf.size());
  endtask

  task automatic test_backpressure();
    write_transport(1'b0);
    send_idle_pct = 0;
    stall_pct     = 0;
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    pdu_buf = '{8'h09, mrd_pkg::FcReadCoils, 8'd60};
    repeat (60) add_pdu_byte(8'($urandom));
    wrap_pdu(1'b0, 16'h0000);
    send_slice(0, frame_buf.size());
    // sender holds back until the block has emptied
    wait_drain();
    pdu_buf = '{8'h0A, mrd_pkg::FcReadHolding, 8'd6, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05,
                8'h06};
    wrap_pdu(1'b0, 16'h0000);
    send_slice(0, frame_buf.size());
  endtask

  // frames longer than the 512-byte limit at which the position counter saturates
  task automatic test_saturation();
    send_idle_pct = 0;
    stall_pct     = 0;
    write_transport(1'b0);
    pdu_buf = '{8'h33, mrd_pkg::FcReadInput, 8'hFE};
    repeat (509) add_pdu_byte(8'($urandom));
    wrap_pdu(1'b0, 16'h0000);
    send_slice(0, frame_buf.size());
    write_transport(1'b1);
    pdu_buf = '{8'h44, mrd_pkg::FcReadCoils, 8'hFF};
    repeat (520) add_pdu_byte(8'($urandom));
    wrap_pdu(1'b1, 16'h5AA5);
    send_slice(0, frame_buf.size());
  endtask

  task automatic test_random_traffic();
    int idle_tab[4];
    int stall_tab[4];
    int sent;
    idle_tab  = '{0, 83, 0, 21};
    stall_tab = '{0, 0, 83, 21};
    for (int p = 0; p < 4; p++) begin
      for (int m = 0; m < 2; m++) begin
        write_transport(m[0]);
        send_idle_pct = idle_tab[p];
        stall_pct     = stall_tab[p];
        sent = 0;
        while (sent < PhaseBytes) begin
          make_random_frame(m[0]);
          send_slice(0, frame_buf.size());
          sent += frame_buf.size();
        end
      end
    end
  endtask

  initial begin
    rst_n                  = 1'b0;
    in_bus.valid           = 1'b0;
    in_bus.frame_byte      = 8'h00;
    in_bus.frame_end       = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.transport_mode = 1'b0;
    mode_tcp               = 1'b0;
    send_idle_pct          = 0;
    stall_pct              = 0;
    hold_req               = 1'b0;
    hold_left              = 0;
    mismatches             = 0;
    bytes_taken            = 0;
    in_stalls              = 0;
    elements_checked       = 0;
    summaries_checked      = 0;
    quiet_cycles           = 0;
    status_seen            = '0;
    clear_frame();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_rtu_basic();
    test_tcp_basic();
    test_mode_switch_midframe();
    test_backpressure();
    test_saturation();
    test_random_traffic();

    wait_drain();
    $display("covered %0d bytes: %0d payload elements and %0d frame summaries, RTU and TCP",
             bytes_taken, elements_checked, summaries_checked);
    $display("input held off on %0d cycles; summary status codes seen (bit per code) %b",
             in_stalls, status_seen);
    if (mismatches == 0) begin
      $display("** modbus_response_deframer: PASSED **");
    end else begin
      $display("** modbus_response_deframer: FAILED **");
    end
    $finish;
  end

endmodule
